// ===== rtl/core/fslt_pkg.sv =====
// Shared types and constants for the flow sequence loss tracker.
package fslt_pkg;

  localparam logic [1:0] REQ_PKT    = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_RETIRE = 2'd2;

  localparam logic [2:0] ST_KNOWN = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_OLD   = 3'd2;
  localparam logic [2:0] ST_BAD   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  localparam logic [1:0] CLS_IN_ORDER = 2'd0;
  localparam logic [1:0] CLS_GAP      = 2'd1;
  localparam logic [1:0] CLS_DUP      = 2'd2;
  localparam logic [1:0] CLS_OOO      = 2'd3;

  localparam logic [30:0] WRAP_RESET = 31'd100000;
  localparam logic [47:0] CRC_BYTES  = 48'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        in_range;
    logic        header_ok;
    logic [15:0] slot;
    logic [7:0]  flow_gen;
    logic [31:0] seq_num;
    logic [13:0] frame_len;
    logic [63:0] latency;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  flow_status;
    logic [1:0]  seq_class;
    logic [63:0] latency_ticks;
    logic [31:0] seq_err_count;
    logic [31:0] dup_count;
    logic [31:0] ooo_count;
    logic [31:0] too_low_count;
    logic [31:0] too_big_count;
    logic [31:0] pkt_count;
    logic [47:0] byte_count;
    logic [31:0] bad_header_count;
    logic [31:0] old_flow_count;
  } rsp_t;

endpackage

// ===== rtl/core/fslt_front.sv =====
// Front end: accepts requests, checks slot range, computes latency, queues commands.
module fslt_front #(
  parameter int SLOTS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        slot_i,
  input  logic               header_ok_i,
  input  logic [7:0]         flow_gen_i,
  input  logic [31:0]        seq_num_i,
  input  logic [13:0]        frame_len_i,
  input  logic [63:0]        now_tick_i,
  input  logic [63:0]        sent_tick_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output fslt_pkg::cmd_t     cmd_o
);

  fslt_pkg::cmd_t q0_q, q1_q, q0_d, q1_d, in_cmd;
  logic [1:0] cnt_q, cnt_d;
  logic push, pop;

  always_comb begin
    in_cmd.req_type  = req_type_i;
    in_cmd.in_range  = ({16'd0, slot_i} < 32'(SLOTS));
    in_cmd.header_ok = header_ok_i;
    in_cmd.slot      = slot_i;
    in_cmd.flow_gen  = flow_gen_i;
    in_cmd.seq_num   = seq_num_i;
    in_cmd.frame_len = frame_len_i;
    in_cmd.latency   = now_tick_i - sent_tick_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q0_q;
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    q0_d = q0_q;
    q1_d = q1_q;
    cnt_d = cnt_q;
    if (pop) begin
      q0_d = q1_q;
    end
    if (push) begin
      if (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)) begin
        q0_d = in_cmd;
      end else begin
        q1_d = in_cmd;
      end
    end
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_pop_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop count");
`endif

endmodule

// ===== rtl/core/fslt_back.sv =====
// Back end: slot memory read-modify-write, sequence classification and result register.
module fslt_back #(
  parameter int SLOTS = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [30:0]     wrap_window_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  fslt_pkg::cmd_t  cmd_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output fslt_pkg::rsp_t  rsp_o
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0] valid_q, valid_d;
  logic [SLOTS-1:0] cnt_ok_q, cnt_ok_d;
  logic [7:0]  cur_mem  [SLOTS];
  logic [7:0]  old_mem  [SLOTS];
  logic [31:0] exp_mem  [SLOTS];
  logic [31:0] err_mem  [SLOTS];
  logic [31:0] dup_mem  [SLOTS];
  logic [31:0] ooo_mem  [SLOTS];
  logic [31:0] low_mem  [SLOTS];
  logic [31:0] big_mem  [SLOTS];
  logic [31:0] pkt_mem  [SLOTS];
  logic [47:0] byt_mem  [SLOTS];

  logic [7:0]  cur_r, old_r;
  logic [31:0] exp_r, err_r, dup_r, ooo_r, low_r, big_r, pkt_r;
  logic [47:0] byt_r;

  logic busy_q, busy_d;
  fslt_pkg::cmd_t cmd_q;
  logic [AW-1:0] addr, addr_q;
  logic [31:0] bad_q, bad_d, oldc_q, oldc_d;
  logic out_v_q, out_v_d;
  fslt_pkg::rsp_t out_q, out_d;

  logic sv, cok, good, wr, behind, gap;
  logic [7:0]  cur_v, old_v, cur_n, old_n;
  logic [31:0] exp_v, err_v, dup_v, ooo_v, low_v, big_v, pkt_v;
  logic [47:0] byt_v;
  logic [31:0] exp_n, err_n, dup_n, ooo_n, low_n, big_n, pkt_n, seq_dist;
  logic [47:0] byt_n;
  logic [2:0]  st;
  logic [1:0]  cls;

  assign addr = cmd_i.slot[AW-1:0];
  assign cmd_ready_o = !busy_q && (!out_v_q || rsp_ready_i);
  assign rsp_valid_o = out_v_q;
  assign rsp_o = out_q;

  always_ff @(posedge clk_i) begin
    cur_r <= cur_mem[addr];
    old_r <= old_mem[addr];
    exp_r <= exp_mem[addr];
    err_r <= err_mem[addr];
    dup_r <= dup_mem[addr];
    ooo_r <= ooo_mem[addr];
    low_r <= low_mem[addr];
    big_r <= big_mem[addr];
    pkt_r <= pkt_mem[addr];
    byt_r <= byt_mem[addr];
    if (cmd_valid_i && cmd_ready_o) begin
      cmd_q  <= cmd_i;
      addr_q <= addr;
    end
    if (wr) begin
      cur_mem[addr_q] <= cur_n;
      old_mem[addr_q] <= old_n;
      exp_mem[addr_q] <= exp_n;
      err_mem[addr_q] <= err_n;
      dup_mem[addr_q] <= dup_n;
      ooo_mem[addr_q] <= ooo_n;
      low_mem[addr_q] <= low_n;
      big_mem[addr_q] <= big_n;
      pkt_mem[addr_q] <= pkt_n;
      byt_mem[addr_q] <= byt_n;
    end
    out_q <= out_d;
  end

  always_comb begin
    sv  = valid_q[addr_q];
    cok = cnt_ok_q[addr_q];
    cur_v = cok ? cur_r : 8'd0;
    old_v = cok ? old_r : 8'd0;
    exp_v = cok ? exp_r : 32'd0;
    err_v = cok ? err_r : 32'd0;
    dup_v = cok ? dup_r : 32'd0;
    ooo_v = cok ? ooo_r : 32'd0;
    low_v = cok ? low_r : 32'd0;
    big_v = cok ? big_r : 32'd0;
    pkt_v = cok ? pkt_r : 32'd0;
    byt_v = cok ? byt_r : 48'd0;
    cur_n = cur_v; old_n = old_v; exp_n = exp_v; err_n = err_v;
    dup_n = dup_v; ooo_n = ooo_v; low_n = low_v; big_n = big_v;
    pkt_n = pkt_v; byt_n = byt_v;
    valid_d = valid_q;
    cnt_ok_d = cnt_ok_q;
    bad_d = bad_q;
    oldc_d = oldc_q;
    good = 1'b0;
    st = fslt_pkg::ST_READ;
    cls = fslt_pkg::CLS_IN_ORDER;
    wr = 1'b0;
    behind = 1'b0;
    gap = 1'b0;
    seq_dist = 32'd0;
    if (busy_q) begin
      if (cmd_q.req_type == fslt_pkg::REQ_PKT) begin
        priority if (!cmd_q.header_ok || !cmd_q.in_range) begin
          bad_d = bad_q + 32'd1;
          st = fslt_pkg::ST_BAD;
        end else if (sv && cur_v == cmd_q.flow_gen) begin
          good = 1'b1;
          st = fslt_pkg::ST_KNOWN;
        end else if (old_v == cmd_q.flow_gen) begin
          oldc_d = oldc_q + 32'd1;
          st = fslt_pkg::ST_OLD;
        end else if (!sv) begin
          valid_d[addr_q] = 1'b1;
          cur_n = cmd_q.flow_gen;
          good = 1'b1;
          st = fslt_pkg::ST_FIRST;
        end else begin
          bad_d = bad_q + 32'd1;
          st = fslt_pkg::ST_BAD;
        end
        if (good) begin
          wr = 1'b1;
          cnt_ok_d[addr_q] = 1'b1;
          if (cmd_q.seq_num == exp_v) begin
            exp_n = cmd_q.seq_num + 32'd1;
          end else if (cmd_q.seq_num < exp_v) begin
            seq_dist = exp_v - cmd_q.seq_num;
            if (seq_dist > {1'b0, wrap_window_i}) gap = 1'b1;
            else behind = 1'b1;
          end else begin
            seq_dist = cmd_q.seq_num - exp_v;
            if (seq_dist > {1'b0, wrap_window_i}) behind = 1'b1;
            else gap = 1'b1;
          end
          if (gap) begin
            err_n = err_v + (cmd_q.seq_num - exp_v);
            big_n = big_v + 32'd1;
            exp_n = cmd_q.seq_num + 32'd1;
            cls = fslt_pkg::CLS_GAP;
          end
          if (behind) begin
            if (cmd_q.seq_num == exp_v - 32'd1) begin
              dup_n = dup_v + 32'd1;
              cls = fslt_pkg::CLS_DUP;
            end else begin
              ooo_n = ooo_v + 32'd1;
              err_n = err_v - 32'd1;
              cls = fslt_pkg::CLS_OOO;
            end
            low_n = low_v + 32'd1;
          end
          pkt_n = pkt_v + 32'd1;
          byt_n = byt_v + {34'd0, cmd_q.frame_len} + fslt_pkg::CRC_BYTES;
        end
      end else if (cmd_q.req_type == fslt_pkg::REQ_RETIRE && cmd_q.in_range) begin
        wr = 1'b1;
        cnt_ok_d[addr_q] = 1'b1;
        if (sv) old_n = cur_v;
        valid_d[addr_q] = 1'b0;
        exp_n = 32'd0;
      end
    end
    out_d = out_q;
    out_v_d = out_v_q;
    if (out_v_q && rsp_ready_i) out_v_d = 1'b0;
    if (busy_q) begin
      out_v_d = 1'b1;
      out_d.flow_status = st;
      out_d.seq_class = cls;
      out_d.latency_ticks = good ? cmd_q.latency : 64'd0;
      out_d.seq_err_count = cmd_q.in_range ? err_n : 32'd0;
      out_d.dup_count = cmd_q.in_range ? dup_n : 32'd0;
      out_d.ooo_count = cmd_q.in_range ? ooo_n : 32'd0;
      out_d.too_low_count = cmd_q.in_range ? low_n : 32'd0;
      out_d.too_big_count = cmd_q.in_range ? big_n : 32'd0;
      out_d.pkt_count = cmd_q.in_range ? pkt_n : 32'd0;
      out_d.byte_count = cmd_q.in_range ? byt_n : 48'd0;
      out_d.bad_header_count = bad_d;
      out_d.old_flow_count = oldc_d;
    end
    busy_d = cmd_valid_i && cmd_ready_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      cnt_ok_q <= '0;
      busy_q   <= 1'b0;
      out_v_q  <= 1'b0;
      bad_q    <= 32'd0;
      oldc_q   <= 32'd0;
    end else begin
      valid_q  <= valid_d;
      cnt_ok_q <= cnt_ok_d;
      busy_q   <= busy_d;
      out_v_q  <= out_v_d;
      bad_q    <= bad_d;
      oldc_q   <= oldc_d;
    end
  end

`ifndef SYNTHESIS
  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q) else $error("back end took two commands back to back");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> out_v_q) else $error("result not registered");
  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !rsp_ready_i) |-> !cmd_ready_o)
    else $error("command taken over pending result");
`endif

endmodule

// ===== rtl/core/flow_sequence_loss_tracker.sv =====
// Top level of the flow sequence loss tracker.
// Receive sequence checker with SLOTS flow slots held in on-chip memory. Each request
// (packet, read or retire) yields one result. A two-entry command queue separates
// the accepting front end from the back end, which reads the slot memory, then writes
// it back and registers the result. It takes no new command while one is in flight,
// so the read-modify-write limits throughput, nor while a result waits untaken. Slot
// state reads as zero after reset through per-slot valid bits, with no clearing pass.
// wrap_window is to be written through the cfg port only while idle; the block itself does not enforce this.
module flow_sequence_loss_tracker #(
  parameter int SLOTS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] cfg_wrap_window_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] slot_i,
  input  logic        header_ok_i,
  input  logic [7:0]  flow_gen_i,
  input  logic [31:0] seq_num_i,
  input  logic [13:0] frame_len_i,
  input  logic [63:0] now_tick_i,
  input  logic [63:0] sent_tick_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  flow_status_o,
  output logic [1:0]  seq_class_o,
  output logic [63:0] latency_ticks_o,
  output logic [31:0] seq_err_count_o,
  output logic [31:0] dup_count_o,
  output logic [31:0] ooo_count_o,
  output logic [31:0] too_low_count_o,
  output logic [31:0] too_big_count_o,
  output logic [31:0] pkt_count_o,
  output logic [47:0] byte_count_o,
  output logic [31:0] bad_header_count_o,
  output logic [31:0] old_flow_count_o
);

  logic [30:0] wrap_q;
  logic cmd_valid, cmd_ready;
  fslt_pkg::cmd_t cmd;
  fslt_pkg::rsp_t rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= fslt_pkg::WRAP_RESET;
    end else if (cfg_valid_i) begin
      wrap_q <= cfg_wrap_window_i;
    end
  end

  fslt_front #(.SLOTS(SLOTS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .slot_i, .header_ok_i,
    .flow_gen_i, .seq_num_i, .frame_len_i, .now_tick_i, .sent_tick_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  fslt_back #(.SLOTS(SLOTS)) u_back (
    .clk_i, .rst_ni, .wrap_window_i(wrap_q), .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready), .cmd_i(cmd), .rsp_valid_o(out_valid_o),
    .rsp_ready_i(out_ready_i), .rsp_o(rsp)
  );

  assign flow_status_o      = rsp.flow_status;
  assign seq_class_o        = rsp.seq_class;
  assign latency_ticks_o    = rsp.latency_ticks;
  assign seq_err_count_o    = rsp.seq_err_count;
  assign dup_count_o        = rsp.dup_count;
  assign ooo_count_o        = rsp.ooo_count;
  assign too_low_count_o    = rsp.too_low_count;
  assign too_big_count_o    = rsp.too_big_count;
  assign pkt_count_o        = rsp.pkt_count;
  assign byte_count_o       = rsp.byte_count;
  assign bad_header_count_o = rsp.bad_header_count;
  assign old_flow_count_o   = rsp.old_flow_count;

endmodule
